/* rtl/assert_macros.svh */
// Assertion macros used by the checker module of the slot pool allocator.
// Depends on nothing; included by file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is held.
`define FSPA_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define FSPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/fspa_pkg.sv */
// Package of the fixed slot pool allocator: field widths, command and status
// codes, parameter defaults and the result record. Depends on nothing.
package fspa_pkg;

  localparam int FSPA_SLOTS_DEF = 16;

  localparam int IDX_W    = 4;
  localparam int CNT_W    = 5;
  localparam int STATUS_W = 2;

  localparam logic CMD_GET     = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_GRANTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0]    free_count;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    slot;
  } fspa_result_t;

endpackage

/* rtl/fixed_slot_pool_allocator_top.sv */
// Top level of the fixed slot pool allocator: stream ports and result register.
// Depends on fspa_pkg and fspa_ctrl.
//
// Use: each input beat is a request. in_tuser carries the command (get a free
// slot, or release the slot in in_tdata). Each request yields exactly one
// result beat carrying the slot, a status code in out_tuser and the number of
// free slots left.
// Timing: a get or release that moves a slot steps through the evaluate,
// append, terminate and done states before the output register loads; an
// empty pool or a release of a slot not in use goes from evaluate to done.
// The next request is taken only after done, so requests are served one at a
// time. The steps are set by the sequencer spreading the unlink and append
// writes, each of the next and prev link stores having a single write port.
// Reset: a synchronous low rst_n sets the free list to slots 0 to SLOTS-1 in
// order. A clearing pass then writes the link stores, and in_tready stays low
// until it ends.
// Stall: the result sits in an output register; the block goes on with the next
// request while it waits, and only holds its final step when a second result is
// ready before the first is taken.
module fixed_slot_pool_allocator_top #(
  parameter int SLOTS = fspa_pkg::FSPA_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [3:0] slot_index, [7:4] zero
  input  logic [0:0]  in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] slot_out, [8:4] free_count, [15:9] zero
  output logic [1:0]  out_tuser   // [1:0] status
);
  import fspa_pkg::*;

  logic         res_valid, res_ready;
  fspa_result_t res;
  logic         out_valid_r;
  fspa_result_t out_res_r;

  fspa_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(in_tvalid),
    .req_ready(in_tready),
    .req_cmd  (in_tuser[0]),
    .req_idx  (in_tdata[IDX_W-1:0]),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // The output register takes a new result when it is empty or being drained.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_res_r.free_count, out_res_r.slot};
  assign out_tuser  = out_res_r.status;

endmodule

/* rtl/fspa_ctrl.sv */
// Sequencer of the slot pool allocator with the link stores it works on.
// Depends on fspa_pkg.
module fspa_ctrl #(
  parameter int SLOTS = fspa_pkg::FSPA_SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  logic                       req_cmd,
  input  logic [fspa_pkg::IDX_W-1:0] req_idx,
  output logic                       res_valid,
  input  logic                       res_ready,
  output fspa_pkg::fspa_result_t     res
);
  import fspa_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);
  localparam logic [LW-1:0] NIL  = LW'(SLOTS);
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_APPEND = 3'd3;
  localparam logic [2:0] S_TERM   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  // Link stores, one write port and one registered read port each.
  logic [LW-1:0] next_mem_r [SLOTS];
  logic [LW-1:0] prev_mem_r [SLOTS];
  logic          used_mem_r [SLOTS];
  logic [LW-1:0] next_rd_r, prev_rd_r;
  logic          used_rd_r;

  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    init_ptr_r, init_ptr_nxt;
  logic             cmd_r;
  logic [IDX_W-1:0] idx_r;
  logic [AW-1:0]    slot_r;
  logic [LW-1:0]    free_head_r, free_head_nxt, free_tail_r, free_tail_nxt;
  logic [LW-1:0]    used_head_r, used_head_nxt, used_tail_r, used_tail_nxt;
  logic [LW-1:0]    free_total_r, free_total_nxt;
  fspa_result_t     res_r, res_nxt;

  logic          accept;
  logic [AW-1:0] rd_addr;
  logic          next_we, prev_we, used_we;
  logic [AW-1:0] next_wa, prev_wa, used_wa;
  logic [LW-1:0] next_wd, prev_wd;
  logic          used_wd;

  logic          is_get, src_ok;
  logic [LW-1:0] src_head, src_tail, dst_head, dst_tail, slot_link, total_upd;

  assign req_ready = (state_r == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign rd_addr   = (req_cmd == CMD_GET) ? AW'(free_head_r) : AW'(req_idx);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  assign is_get    = (cmd_r == CMD_GET);
  assign slot_link = LW'(slot_r);
  assign src_ok    = is_get ? (free_head_r < NIL)
                            : ((32'(idx_r) < SLOTS) && used_rd_r);
  assign src_head  = is_get ? free_head_r : used_head_r;
  assign src_tail  = is_get ? free_tail_r : used_tail_r;
  assign dst_head  = is_get ? used_head_r : free_head_r;
  assign dst_tail  = is_get ? used_tail_r : free_tail_r;
  assign total_upd = is_get ? (free_total_r - LW'(1)) : (free_total_r + LW'(1));

  always_comb begin
    logic [LW-1:0] sh, st, dh, dt;
    sh = src_head;
    st = src_tail;
    dh = dst_head;
    dt = dst_tail;
    state_nxt      = state_r;
    init_ptr_nxt   = init_ptr_r;
    free_head_nxt  = free_head_r;
    free_tail_nxt  = free_tail_r;
    used_head_nxt  = used_head_r;
    used_tail_nxt  = used_tail_r;
    free_total_nxt = free_total_r;
    res_nxt        = res_r;
    next_we = 1'b0;
    prev_we = 1'b0;
    used_we = 1'b0;
    next_wa = slot_r;
    prev_wa = slot_r;
    used_wa = slot_r;
    next_wd = NIL;
    prev_wd = NIL;
    used_wd = 1'b0;
    case (state_r)
      S_INIT: begin
        // Clearing pass: slot i links forward to i+1 and back to i-1.
        next_we = 1'b1;
        prev_we = 1'b1;
        used_we = 1'b1;
        next_wa = init_ptr_r;
        prev_wa = init_ptr_r;
        used_wa = init_ptr_r;
        next_wd = LW'(init_ptr_r) + LW'(1);
        prev_wd = (init_ptr_r == '0) ? NIL : (LW'(init_ptr_r) - LW'(1));
        init_ptr_nxt = init_ptr_r + AW'(1);
        if (init_ptr_r == LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (src_ok) begin
          // Unlink the slot from its list: prev_rd_r and next_rd_r are its links.
          if (prev_rd_r >= NIL) begin
            sh = next_rd_r;
          end else begin
            next_we = 1'b1;
            next_wa = prev_rd_r[AW-1:0];
            next_wd = next_rd_r;
          end
          if (next_rd_r >= NIL) begin
            st = prev_rd_r;
          end else begin
            prev_we = 1'b1;
            prev_wa = next_rd_r[AW-1:0];
            prev_wd = prev_rd_r;
          end
          state_nxt = S_APPEND;
        end else begin
          res_nxt.slot       = is_get ? '0 : idx_r;
          res_nxt.status     = is_get ? ST_EMPTY : ST_NOT_USED;
          res_nxt.free_count = CNT_W'(free_total_r);
          state_nxt = S_DONE;
        end
      end
      S_APPEND: begin
        prev_we = 1'b1;
        if ((dst_head >= NIL) || (dst_tail >= NIL)) begin
          dh      = slot_link;
          dt      = slot_link;
          prev_wd = NIL;
        end else begin
          next_we = 1'b1;
          next_wa = dst_tail[AW-1:0];
          next_wd = slot_link;
          prev_wd = dst_tail;
          dt      = slot_link;
        end
        state_nxt = S_TERM;
      end
      S_TERM: begin
        next_we = 1'b1;
        next_wd = NIL;
        used_we = 1'b1;
        used_wd = is_get;
        free_total_nxt     = total_upd;
        res_nxt.slot       = is_get ? IDX_W'(slot_r) : idx_r;
        res_nxt.status     = is_get ? ST_GRANTED : ST_RELEASED;
        res_nxt.free_count = CNT_W'(total_upd);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (is_get) begin
      free_head_nxt = (state_r == S_EVAL) ? sh : free_head_r;
      free_tail_nxt = (state_r == S_EVAL) ? st : free_tail_r;
      used_head_nxt = (state_r == S_APPEND) ? dh : used_head_r;
      used_tail_nxt = (state_r == S_APPEND) ? dt : used_tail_r;
    end else begin
      used_head_nxt = (state_r == S_EVAL) ? sh : used_head_r;
      used_tail_nxt = (state_r == S_EVAL) ? st : used_tail_r;
      free_head_nxt = (state_r == S_APPEND) ? dh : free_head_r;
      free_tail_nxt = (state_r == S_APPEND) ? dt : free_tail_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      init_ptr_r   <= '0;
      free_head_r  <= '0;
      free_tail_r  <= LW'(SLOTS - 1);
      used_head_r  <= NIL;
      used_tail_r  <= NIL;
      free_total_r <= LW'(SLOTS);
    end else begin
      state_r      <= state_nxt;
      init_ptr_r   <= init_ptr_nxt;
      free_head_r  <= free_head_nxt;
      free_tail_r  <= free_tail_nxt;
      used_head_r  <= used_head_nxt;
      used_tail_r  <= used_tail_nxt;
      free_total_r <= free_total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (accept) begin
      cmd_r  <= req_cmd;
      idx_r  <= req_idx;
      slot_r <= rd_addr;
    end
  end

  // Link stores: reads are taken only when a request is accepted.
  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem_r[next_wa] <= next_wd;
    end
    if (accept) begin
      next_rd_r <= next_mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem_r[prev_wa] <= prev_wd;
    end
    if (accept) begin
      prev_rd_r <= prev_mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (used_we) begin
      used_mem_r[used_wa] <= used_wd;
    end
    if (accept) begin
      used_rd_r <= used_mem_r[rd_addr];
    end
  end

endmodule

/* rtl/fspa_checker.sv */
// Port-level checker of the fixed slot pool allocator and its bind statement.
// Depends on fspa_pkg, assert_macros.svh and fixed_slot_pool_allocator_top.
`include "assert_macros.svh"

module fspa_checker #(
  parameter int SLOTS = fspa_pkg::FSPA_SLOTS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import fspa_pkg::*;

  // Requests are served one at a time: no beat right after an accepted one.
  `FSPA_ASSERT_RST(a_one_at_a_time, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready, "request accepted back to back")

  // A stalled result stays offered.
  `FSPA_ASSERT_RST(a_out_hold, clk, rst_n, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)), "stalled result changed")

  // An empty pool report comes with a free count of zero.
  `FSPA_ASSERT_RST(a_empty_count, clk, rst_n, (out_tvalid && (out_tuser == ST_EMPTY)) |-> (out_tdata[8:4] == 5'd0), "empty report with free slots")

  // Reset drops the result and blocks requests while the link stores clear.
  `FSPA_ASSERT_ALWAYS(a_reset, clk, !rst_n |=> (!out_tvalid && !in_tready), "reset did not quiesce the ports")

endmodule

bind fixed_slot_pool_allocator_top fspa_checker #(
  .SLOTS(SLOTS)
) u_fspa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

/* sim/tb_fixed_slot_pool_allocator_top.sv */
// Self-checking testbench for fixed_slot_pool_allocator_top: directed and random
// get/release requests checked against a linked-list model of the slot pool.
// Depends on fspa_pkg and the allocator RTL; needs no files or arguments.
`timescale 1ns / 100ps

module tb_fixed_slot_pool_allocator_top;
  import fspa_pkg::*;

  localparam int          POOL_SLOTS   = FSPA_SLOTS_DEF;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          SETTLE_TICKS = 20;
  localparam logic [4:0]  LINK_NONE    = 5'(POOL_SLOTS);

  typedef logic [4:0] link_t;
  typedef enum int {POOL_AVAIL = 0, POOL_TAKEN = 1} pool_list_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;

  // Idle shaping: when a flag is set, that side runs back to back.
  bit sender_calm = 1'b0;
  bit sink_calm   = 1'b0;

  int          fail_count  = 0;
  int unsigned cycle_count = 0;

  // Results predicted at the accepting edge of each request, oldest first.
  fspa_result_t pending_results[$];

  // Pool model: both lists are threaded through one pair of link stores.
  link_t link_next [POOL_SLOTS];
  link_t link_prev [POOL_SLOTS];
  link_t list_head [2];
  link_t list_tail [2];
  bit    slot_busy [POOL_SLOTS];
  logic [4:0] free_total;

  fixed_slot_pool_allocator_top #(
    .SLOTS(POOL_SLOTS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Pool model
  // ---------------------------------------------------------------------------

  // Power-up layout: every slot on the free list in ascending order.
  function automatic void reset_pool_model();
    for (int i = 0; i < POOL_SLOTS; i++) begin
      link_next[i] = (i + 1 < POOL_SLOTS) ? link_t'(i + 1) : LINK_NONE;
      link_prev[i] = (i > 0) ? link_t'(i - 1) : LINK_NONE;
      slot_busy[i] = 1'b0;
    end
    list_head[POOL_AVAIL] = '0;
    list_tail[POOL_AVAIL] = link_t'(POOL_SLOTS - 1);
    list_head[POOL_TAKEN] = LINK_NONE;
    list_tail[POOL_TAKEN] = LINK_NONE;
    free_total = 5'(POOL_SLOTS);
  endfunction

  function automatic void unlink_slot(pool_list_t lst, link_t s);
    link_t p, n;
    p = link_prev[s];
    n = link_next[s];
    if (p >= POOL_SLOTS) list_head[lst] = n;
    else                 link_next[p] = n;
    if (n >= POOL_SLOTS) list_tail[lst] = p;
    else                 link_prev[n] = p;
  endfunction

  function automatic void append_slot(pool_list_t lst, link_t s);
    if (list_head[lst] >= POOL_SLOTS || list_tail[lst] >= POOL_SLOTS) begin
      list_head[lst] = s;
      list_tail[lst] = s;
      link_prev[s]   = LINK_NONE;
    end else begin
      link_next[list_tail[lst]] = s;
      link_prev[s]              = list_tail[lst];
      list_tail[lst]            = s;
    end
    link_next[s] = LINK_NONE;
  endfunction

  // Applies one request to the model and returns the result it must produce.
  function automatic fspa_result_t apply_request(logic cmd, logic [IDX_W-1:0] idx);
    fspa_result_t r;
    link_t        s;
    r = '0;
    if (cmd == CMD_GET) begin
      if (list_head[POOL_AVAIL] >= POOL_SLOTS) begin
        r.status = ST_EMPTY;
      end else begin
        s = list_head[POOL_AVAIL];
        unlink_slot(POOL_AVAIL, s);
        append_slot(POOL_TAKEN, s);
        slot_busy[s] = 1'b1;
        free_total   = free_total - 5'd1;
        r.slot       = s[IDX_W-1:0];
        r.status     = ST_GRANTED;
      end
    end else begin
      r.slot = idx;
      if (int'(idx) < POOL_SLOTS && slot_busy[idx]) begin
        s = link_t'(idx);
        unlink_slot(POOL_TAKEN, s);
        append_slot(POOL_AVAIL, s);
        slot_busy[s] = 1'b0;
        free_total   = free_total + 5'd1;
        r.status     = ST_RELEASED;
      end else begin
        r.status = ST_NOT_USED;
      end
    end
    r.free_count = free_total;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Presents one request beat after a random gap and waits for the accepting
  // edge, where the expected result is worked out. Called only at a clock edge.
  task automatic send_request(input logic cmd, input logic [IDX_W-1:0] idx);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(8 - IDX_W){1'b0}}, idx};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_request(cmd, idx));
  endtask

  // Holds the request side off until every predicted result has been taken.
  // It always waits on the clock, so valid is never lowered and raised in one step.
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // The sink stalls a random number of cycles before taking each result beat.
  initial begin : result_sink
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = sink_calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Every accepted result beat is matched field by field against the oldest
  // prediction. Values are read right at the edge, before any update lands.
  always @(posedge clk) begin : result_check
    fspa_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: slot_out %0d status %0d",
               out_tdata[IDX_W-1:0], out_tuser);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[IDX_W-1:0] !== want.slot) begin
          $error("slot_out mismatch: expected %0d, got %0d",
                 want.slot, out_tdata[IDX_W-1:0]);
          fail_count++;
        end
        if (out_tuser !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_tuser);
          fail_count++;
        end
        if (out_tdata[IDX_W+CNT_W-1:IDX_W] !== want.free_count) begin
          $error("free_count mismatch: expected %0d, got %0d",
                 want.free_count, out_tdata[IDX_W+CNT_W-1:IDX_W]);
          fail_count++;
        end
        if (out_tdata[15:IDX_W+CNT_W] !== '0) begin
          $error("tdata padding mismatch: expected 0, got %0h",
                 out_tdata[15:IDX_W+CNT_W]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("run timed out after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Releasing slots that were never granted must be flagged and change nothing;
  // the pool is still full, so free_count reads its maximum.
  task automatic test_release_unused();
    send_request(CMD_RELEASE, '0);
    send_request(CMD_RELEASE, '1);
  endtask

  // Grants come out in ascending order until the pool runs dry; further gets
  // report an empty pool with slot 0. The ignored index is random.
  task automatic test_exhaust_pool();
    for (int i = 0; i < POOL_SLOTS + 2; i++)
      send_request(CMD_GET, IDX_W'($urandom_range(0, POOL_SLOTS - 1)));
  endtask

  // Unlinks at the tail, the head and the middle of the used list, a double
  // release, and then gets that must return slots in the order they were freed.
  task automatic test_release_positions();
    send_request(CMD_RELEASE, IDX_W'(POOL_SLOTS - 1));
    send_request(CMD_RELEASE, '0);
    send_request(CMD_RELEASE, IDX_W'(7));
    send_request(CMD_RELEASE, IDX_W'(7));
    send_request(CMD_GET, '0);
    send_request(CMD_GET, '1);
    wait_all_results();
  endtask

  // Mostly well-formed traffic: gets and releases of slots in use, with the
  // get share varied per segment so the pool swings between full and empty.
  // A few releases name arbitrary slots. Halfway the sender drains the block.
  task automatic test_random_traffic(input int segments, input int per_segment);
    int busy_list[$];
    int get_pct;
    int pick;
    for (int seg = 0; seg < segments; seg++) begin
      case ($urandom_range(0, 2))
        0:       get_pct = 15;
        1:       get_pct = 50;
        default: get_pct = 85;
      endcase
      sender_calm = ($urandom_range(0, 3) == 0);
      sink_calm   = ($urandom_range(0, 3) == 0);
      if (seg == segments / 2) wait_all_results();
      for (int n = 0; n < per_segment; n++) begin
        busy_list.delete();
        for (int i = 0; i < POOL_SLOTS; i++)
          if (slot_busy[i]) busy_list.push_back(i);
        if ($urandom_range(0, 99) < get_pct) begin
          send_request(CMD_GET, IDX_W'($urandom_range(0, POOL_SLOTS - 1)));
        end else if (busy_list.size() != 0 && $urandom_range(0, 9) < 8) begin
          pick = busy_list[$urandom_range(0, busy_list.size() - 1)];
          send_request(CMD_RELEASE, IDX_W'(pick));
        end else begin
          send_request(CMD_RELEASE, IDX_W'($urandom_range(0, POOL_SLOTS - 1)));
        end
      end
    end
    sender_calm = 1'b0;
    sink_calm   = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  // Reset is held at the start; the block then runs its clearing pass with
  // in_tready low, which the request side simply waits out.
  initial begin
    reset_pool_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_release_unused();
    test_exhaust_pool();
    test_release_positions();
    test_random_traffic(9, 50);

    wait_all_results();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/fspa_pkg.sv
rtl/fspa_ctrl.sv
rtl/fixed_slot_pool_allocator_top.sv
rtl/fspa_checker.sv
sim/tb_fixed_slot_pool_allocator_top.sv
